// ----- rtl/swm_pkg.sv -----
// Shared widths, register indexes and transaction payload types for the
// stick-to-wheel speed mixer. No dependencies.
`default_nettype none

package swm_pkg;

    localparam int CHANNEL_BITS = 11;
    localparam int CFG_CH_W     = 11;
    localparam int GAIN_BITS    = 16;
    localparam int LIMIT_BITS   = 15;
    localparam int OUT_BITS     = 15;
    localparam int MODE_BITS    = 2;
    localparam int GAIN_FRAC    = 10;
    localparam int MAG_FRAC     = 4;
    localparam int RAD_SHIFT    = 2 * MAG_FRAC;

    localparam int ST_W        = (CHANNEL_BITS > CFG_CH_W) ? CHANNEL_BITS : CFG_CH_W;
    localparam int SQ_W        = 2 * ST_W;
    localparam int SUM_W       = SQ_W + 1;
    localparam int RAD_W       = SUM_W + RAD_SHIFT;
    localparam int ROOT_W      = (RAD_W + 1) / 2;
    localparam int SQRT_STEPS  = 4;
    localparam int SQRT_STAGES = (ROOT_W + SQRT_STEPS - 1) / SQRT_STEPS;
    localparam int SQRT_ITER   = SQRT_STAGES * SQRT_STEPS;
    localparam int PAD_W       = 2 * SQRT_ITER;
    localparam int REM_W       = SQRT_ITER + 2;
    localparam int PROD_W      = ST_W + GAIN_BITS;
    localparam int SCALE_W     = PROD_W - GAIN_FRAC;
    localparam int MAGP_W      = ROOT_W + GAIN_BITS;
    localparam int SPD_W       = MAGP_W - (GAIN_FRAC + MAG_FRAC);

    localparam int IN_DATA_W  = ((4 * CHANNEL_BITS + 7) / 8) * 8;
    localparam int OUT_DATA_W = ((4 * OUT_BITS + 7) / 8) * 8;
    localparam int CFG_W      = 16;
    localparam int CFG_IDX_W  = 3;

    localparam logic [OUT_BITS-1:0] OUT_MAX = {1'b0, {(OUT_BITS-1){1'b1}}};

    localparam logic [CFG_IDX_W-1:0] REG_STICK_CENTER   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DEADBAND_LOW   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DEADBAND_HIGH  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPEED_GAIN     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SPEED_LIMIT    = 3'd4;

    localparam logic [CFG_CH_W-1:0]   CENTER_RST = 11'd1024;
    localparam logic [CFG_CH_W-1:0]   DB_LOW_RST = 11'd900;
    localparam logic [CFG_CH_W-1:0]   DB_HIGH_RST = 11'd1148;
    localparam logic [GAIN_BITS-1:0]  GAIN_RST   = 16'd13265;
    localparam logic [LIMIT_BITS-1:0] LIMIT_RST  = 15'd8550;

    typedef enum logic [MODE_BITS-1:0] {
        MODE_TRANSLATE = 2'd0,
        MODE_ROTATE    = 2'd1,
        MODE_AUX       = 2'd2,
        MODE_STOP      = 2'd3
    } drive_mode_t;

    typedef enum logic [1:0] {
        MIX_ZERO,
        MIX_TRANS,
        MIX_ROT,
        MIX_AUX
    } mix_kind_t;

    typedef struct packed {
        logic [CFG_CH_W-1:0]   stick_center;
        logic [CFG_CH_W-1:0]   deadband_low;
        logic [CFG_CH_W-1:0]   deadband_high;
        logic [GAIN_BITS-1:0]  speed_gain_q10;
        logic [LIMIT_BITS-1:0] speed_limit;
    } cfg_t;

    typedef struct packed {
        logic [MODE_BITS-1:0]    drive_mode;
        logic [CHANNEL_BITS-1:0] turn_channel;
        logic [CHANNEL_BITS-1:0] aux_channel;
        logic [CHANNEL_BITS-1:0] lateral_channel;
        logic [CHANNEL_BITS-1:0] longitudinal_channel;
    } stick_t;

    typedef struct packed {
        logic                       trans;
        logic signed [OUT_BITS-1:0] left;
        logic signed [OUT_BITS-1:0] right;
    } side_t;

    typedef struct packed {
        logic [PAD_W-1:0]     rad;
        logic [REM_W-1:0]     rem;
        logic [SQRT_ITER-1:0] root;
        side_t                side;
    } root_t;

    typedef struct packed {
        logic signed [OUT_BITS-1:0] front_left_speed;
        logic signed [OUT_BITS-1:0] rear_left_speed;
        logic signed [OUT_BITS-1:0] rear_right_speed;
        logic signed [OUT_BITS-1:0] front_right_speed;
    } speeds_t;

endpackage

`default_nettype wire

// ----- rtl/swm_front.sv -----
// Front end: stick offsets, deadband test, squares and offset gain product,
// then radicand and scaled rotation/aux speed. Uses swm_pkg.
`default_nettype none

module swm_front (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire swm_pkg::cfg_t  cfg,
    input  wire logic           in_valid,
    output logic                in_ready,
    input  wire swm_pkg::stick_t in_data,
    output logic                out_valid,
    input  wire logic           out_ready,
    output swm_pkg::root_t      out_data
);

    function automatic logic [swm_pkg::ST_W:0] offset_of(
        input logic [swm_pkg::ST_W-1:0] ch,
        input logic [swm_pkg::ST_W-1:0] center
    );
        return {1'b0, ch} - {1'b0, center};
    endfunction

    function automatic logic [swm_pkg::ST_W-1:0] abs_of(input logic [swm_pkg::ST_W:0] off);
        logic [swm_pkg::ST_W:0] m;
        m = off[swm_pkg::ST_W] ? (~off + 1'b1) : off;
        return m[swm_pkg::ST_W-1:0];
    endfunction

    logic [swm_pkg::ST_W-1:0] turn_w, aux_w, lat_w, lon_w;
    logic [swm_pkg::ST_W-1:0] center_w, dbl_w, dbh_w;
    logic                     defl_turn, defl_aux, defl_lat, defl_lon;
    logic [swm_pkg::ST_W:0]   off_lat, off_lon, off_sel;
    logic [swm_pkg::ST_W-1:0] abs_lat, abs_lon, abs_sel;
    swm_pkg::mix_kind_t       kind;

    logic                         a_valid_reg;
    swm_pkg::mix_kind_t           a_kind_reg;
    logic [swm_pkg::SQ_W-1:0]     a_sq_lat_reg, a_sq_lon_reg;
    logic [swm_pkg::PROD_W-1:0]   a_prod_reg;
    logic                         a_neg_reg;

    logic                         b_valid_reg;
    swm_pkg::root_t               b_data_reg;
    swm_pkg::root_t               b_next;

    logic [swm_pkg::SUM_W-1:0]     sum;
    logic [swm_pkg::RAD_W-1:0]     rad;
    logic [swm_pkg::SCALE_W-1:0]   scaled;
    logic [swm_pkg::OUT_BITS-1:0]  mag;
    logic signed [swm_pkg::OUT_BITS-1:0] val;

    logic rdy_a, rdy_b;

    assign rdy_b    = !b_valid_reg || out_ready;
    assign rdy_a    = !a_valid_reg || rdy_b;
    assign in_ready = rdy_a;

    always_comb begin
        turn_w   = swm_pkg::ST_W'(in_data.turn_channel);
        aux_w    = swm_pkg::ST_W'(in_data.aux_channel);
        lat_w    = swm_pkg::ST_W'(in_data.lateral_channel);
        lon_w    = swm_pkg::ST_W'(in_data.longitudinal_channel);
        center_w = swm_pkg::ST_W'(cfg.stick_center);
        dbl_w    = swm_pkg::ST_W'(cfg.deadband_low);
        dbh_w    = swm_pkg::ST_W'(cfg.deadband_high);

        defl_turn = (turn_w < dbl_w) || (turn_w > dbh_w);
        defl_aux  = (aux_w < dbl_w) || (aux_w > dbh_w);
        defl_lat  = (lat_w < dbl_w) || (lat_w > dbh_w);
        defl_lon  = (lon_w < dbl_w) || (lon_w > dbh_w);

        off_lat = offset_of(lat_w, center_w);
        off_lon = offset_of(lon_w, center_w);
        off_sel = offset_of((in_data.drive_mode == swm_pkg::MODE_ROTATE) ? turn_w : aux_w,
                            center_w);
        abs_lat = abs_of(off_lat);
        abs_lon = abs_of(off_lon);
        abs_sel = abs_of(off_sel);

        unique case (in_data.drive_mode)
            swm_pkg::MODE_TRANSLATE: kind = (defl_lat || defl_lon) ? swm_pkg::MIX_TRANS
                                                                   : swm_pkg::MIX_ZERO;
            swm_pkg::MODE_ROTATE:    kind = defl_turn ? swm_pkg::MIX_ROT : swm_pkg::MIX_ZERO;
            swm_pkg::MODE_AUX:       kind = defl_aux ? swm_pkg::MIX_AUX : swm_pkg::MIX_ZERO;
            default:                 kind = swm_pkg::MIX_ZERO;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else if (rdy_a) begin
            a_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy_a && in_valid) begin
            a_kind_reg   <= kind;
            a_sq_lat_reg <= swm_pkg::SQ_W'(abs_lat) * swm_pkg::SQ_W'(abs_lat);
            a_sq_lon_reg <= swm_pkg::SQ_W'(abs_lon) * swm_pkg::SQ_W'(abs_lon);
            a_prod_reg   <= swm_pkg::PROD_W'(abs_sel) * swm_pkg::PROD_W'(cfg.speed_gain_q10);
            a_neg_reg    <= off_sel[swm_pkg::ST_W];
        end
    end

    always_comb begin
        sum    = swm_pkg::SUM_W'(a_sq_lat_reg) + swm_pkg::SUM_W'(a_sq_lon_reg);
        rad    = {sum, {swm_pkg::RAD_SHIFT{1'b0}}};
        scaled = a_prod_reg[swm_pkg::PROD_W-1:swm_pkg::GAIN_FRAC];
        mag    = (scaled > swm_pkg::SCALE_W'(swm_pkg::OUT_MAX)) ? swm_pkg::OUT_MAX
                                                               : scaled[swm_pkg::OUT_BITS-1:0];
        val    = a_neg_reg ? -$signed(mag) : $signed(mag);

        b_next      = '0;
        b_next.rad  = swm_pkg::PAD_W'(rad);
        unique case (a_kind_reg)
            swm_pkg::MIX_TRANS: b_next.side.trans = 1'b1;
            swm_pkg::MIX_ROT: begin
                b_next.side.left  = val;
                b_next.side.right = -val;
            end
            swm_pkg::MIX_AUX: begin
                b_next.side.left  = val;
                b_next.side.right = val;
            end
            default: b_next.side = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
        end else if (rdy_b) begin
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy_b && a_valid_reg) begin
            b_data_reg <= b_next;
        end
    end

    assign out_valid = b_valid_reg;
    assign out_data  = b_data_reg;

endmodule

`default_nettype wire

// ----- rtl/swm_isqrt.sv -----
// Pipelined digit-by-digit integer square root of the Q8 radicand, giving the Q4
// magnitude, a fixed number of root bits per stage. Uses swm_pkg.
`default_nettype none

module swm_isqrt (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            in_valid,
    output logic                 in_ready,
    input  wire swm_pkg::root_t  in_data,
    output logic                 out_valid,
    input  wire logic            out_ready,
    output swm_pkg::root_t       out_data
);

    function automatic swm_pkg::root_t sqrt_steps(input swm_pkg::root_t d);
        swm_pkg::root_t               r;
        logic [swm_pkg::REM_W-1:0]    cur;
        logic [swm_pkg::REM_W-1:0]    trial;
        r = d;
        for (int k = 0; k < swm_pkg::SQRT_STEPS; k++) begin
            cur   = {r.rem[swm_pkg::REM_W-3:0], r.rad[swm_pkg::PAD_W-1 -: 2]};
            trial = {r.root, 2'b01};
            r.rad = r.rad << 2;
            if (cur >= trial) begin
                r.rem  = cur - trial;
                r.root = {r.root[swm_pkg::SQRT_ITER-2:0], 1'b1};
            end else begin
                r.rem  = cur;
                r.root = {r.root[swm_pkg::SQRT_ITER-2:0], 1'b0};
            end
        end
        return r;
    endfunction

    logic           valid_reg [swm_pkg::SQRT_STAGES];
    swm_pkg::root_t data_reg  [swm_pkg::SQRT_STAGES];
    logic [swm_pkg::SQRT_STAGES:0] rdy;

    assign rdy[swm_pkg::SQRT_STAGES] = out_ready;
    assign in_ready = rdy[0];

    for (genvar i = 0; i < swm_pkg::SQRT_STAGES; i++) begin : g_stage
        logic           prev_valid;
        swm_pkg::root_t prev_data;

        if (i == 0) begin : g_first
            assign prev_valid = in_valid;
            assign prev_data  = in_data;
        end else begin : g_rest
            assign prev_valid = valid_reg[i-1];
            assign prev_data  = data_reg[i-1];
        end

        assign rdy[i] = !valid_reg[i] || rdy[i+1];

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[i] <= 1'b0;
            end else if (rdy[i]) begin
                valid_reg[i] <= prev_valid;
            end
        end

        always_ff @(posedge aclk) begin
            if (rdy[i] && prev_valid) begin
                data_reg[i] <= sqrt_steps(prev_data);
            end
        end
    end

    assign out_valid = valid_reg[swm_pkg::SQRT_STAGES-1];
    assign out_data  = data_reg[swm_pkg::SQRT_STAGES-1];

endmodule

`default_nettype wire

// ----- rtl/swm_scale.sv -----
// Back end: magnitude times gain, Q14 truncation, limit clamp and wheel
// speed output register. Uses swm_pkg.
`default_nettype none

module swm_scale (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire swm_pkg::cfg_t   cfg,
    input  wire logic            in_valid,
    output logic                 in_ready,
    input  wire swm_pkg::root_t  in_data,
    output logic                 out_valid,
    input  wire logic            out_ready,
    output swm_pkg::speeds_t     out_data
);

    logic                        m_valid_reg;
    logic [swm_pkg::MAGP_W-1:0]  m_prod_reg;
    swm_pkg::side_t              m_side_reg;

    logic                        o_valid_reg;
    swm_pkg::speeds_t            o_data_reg;
    swm_pkg::speeds_t            o_next;

    logic [swm_pkg::SPD_W-1:0]   spd, lim;
    logic [swm_pkg::OUT_BITS-1:0] trans_spd;

    logic rdy_m, rdy_o;

    assign rdy_o    = !o_valid_reg || out_ready;
    assign rdy_m    = !m_valid_reg || rdy_o;
    assign in_ready = rdy_m;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (rdy_m) begin
            m_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy_m && in_valid) begin
            m_prod_reg <= swm_pkg::MAGP_W'(in_data.root[swm_pkg::ROOT_W-1:0])
                        * swm_pkg::MAGP_W'(cfg.speed_gain_q10);
            m_side_reg <= in_data.side;
        end
    end

    always_comb begin
        spd = m_prod_reg[swm_pkg::MAGP_W-1:swm_pkg::GAIN_FRAC+swm_pkg::MAG_FRAC];
        lim = swm_pkg::SPD_W'(cfg.speed_limit);
        if (spd > lim) begin
            spd = lim;
        end
        trans_spd = (spd > swm_pkg::SPD_W'(swm_pkg::OUT_MAX)) ? swm_pkg::OUT_MAX
                                                             : spd[swm_pkg::OUT_BITS-1:0];
        if (m_side_reg.trans) begin
            o_next.front_left_speed  = $signed(trans_spd);
            o_next.rear_left_speed   = $signed(trans_spd);
            o_next.rear_right_speed  = $signed(trans_spd);
            o_next.front_right_speed = $signed(trans_spd);
        end else begin
            o_next.front_left_speed  = m_side_reg.left;
            o_next.rear_left_speed   = m_side_reg.left;
            o_next.rear_right_speed  = m_side_reg.right;
            o_next.front_right_speed = m_side_reg.right;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            o_valid_reg <= 1'b0;
        end else if (rdy_o) begin
            o_valid_reg <= m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy_o && m_valid_reg) begin
            o_data_reg <= o_next;
        end
    end

    assign out_valid = o_valid_reg;
    assign out_data  = o_data_reg;

endmodule

`default_nettype wire

// ----- rtl/stick_to_wheel_speed_mixer.sv -----
// Top level of the stick-to-wheel speed mixer: configuration registers and
// the front end, square root and scale pipeline. Uses swm_pkg, swm_front,
// swm_isqrt and swm_scale.
//
//   channel   direction  handshake          payload
//   s_        in         s_tvalid/s_tready  s_tdata channels, s_tuser drive mode
//   m_        out        m_tvalid/m_tready  m_tdata four wheel speeds
//   cfg_      in         cfg_wr_en          cfg_index, cfg_wdata
//
// One transaction per cycle sustained while m_tready is held high; the pipeline
// runs through front end, square root, then scale and output registers.
// Every stage holds its own valid bit and loads when empty or when the stage
// after it moves, so bubbles close up under a stalled output.
// Synchronous active-low reset clears valid bits and loads register defaults.
`default_nettype none

module stick_to_wheel_speed_mixer (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // turn_channel, aux_channel, lateral_channel, longitudinal_channel
    input  wire logic [swm_pkg::IN_DATA_W-1:0]     s_tdata,
    // drive_mode
    input  wire logic [swm_pkg::MODE_BITS-1:0]     s_tuser,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // front_left_speed, rear_left_speed, rear_right_speed, front_right_speed
    output logic [swm_pkg::OUT_DATA_W-1:0]         m_tdata,
    input  wire logic                              cfg_wr_en,
    input  wire logic [swm_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [swm_pkg::CFG_W-1:0]         cfg_wdata
);

    localparam int CB = swm_pkg::CHANNEL_BITS;
    localparam int OB = swm_pkg::OUT_BITS;

    swm_pkg::cfg_t    cfg_reg;
    swm_pkg::stick_t  stick;
    swm_pkg::root_t   front_data, sqrt_data;
    swm_pkg::speeds_t speeds;
    logic             front_valid, front_ready, sqrt_valid, sqrt_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.stick_center   <= swm_pkg::CENTER_RST;
            cfg_reg.deadband_low   <= swm_pkg::DB_LOW_RST;
            cfg_reg.deadband_high  <= swm_pkg::DB_HIGH_RST;
            cfg_reg.speed_gain_q10 <= swm_pkg::GAIN_RST;
            cfg_reg.speed_limit    <= swm_pkg::LIMIT_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                swm_pkg::REG_STICK_CENTER:
                    cfg_reg.stick_center <= cfg_wdata[swm_pkg::CFG_CH_W-1:0];
                swm_pkg::REG_DEADBAND_LOW:
                    cfg_reg.deadband_low <= cfg_wdata[swm_pkg::CFG_CH_W-1:0];
                swm_pkg::REG_DEADBAND_HIGH:
                    cfg_reg.deadband_high <= cfg_wdata[swm_pkg::CFG_CH_W-1:0];
                swm_pkg::REG_SPEED_GAIN:
                    cfg_reg.speed_gain_q10 <= cfg_wdata[swm_pkg::GAIN_BITS-1:0];
                swm_pkg::REG_SPEED_LIMIT:
                    cfg_reg.speed_limit <= cfg_wdata[swm_pkg::LIMIT_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        stick.drive_mode           = s_tuser;
        stick.turn_channel         = s_tdata[CB-1:0];
        stick.aux_channel          = s_tdata[2*CB-1:CB];
        stick.lateral_channel      = s_tdata[3*CB-1:2*CB];
        stick.longitudinal_channel = s_tdata[4*CB-1:3*CB];
    end

    swm_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_data   (stick),
        .out_valid (front_valid),
        .out_ready (front_ready),
        .out_data  (front_data)
    );

    swm_isqrt u_isqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (front_valid),
        .in_ready  (front_ready),
        .in_data   (front_data),
        .out_valid (sqrt_valid),
        .out_ready (sqrt_ready),
        .out_data  (sqrt_data)
    );

    swm_scale u_scale (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .in_valid  (sqrt_valid),
        .in_ready  (sqrt_ready),
        .in_data   (sqrt_data),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (speeds)
    );

    assign m_tdata = {{(swm_pkg::OUT_DATA_W - 4*OB){1'b0}},
                      speeds.front_right_speed,
                      speeds.rear_right_speed,
                      speeds.rear_left_speed,
                      speeds.front_left_speed};

endmodule

`default_nettype wire
